@@ rtl/core/bep_pkg.sv @@
// Shared types and constants for the button and encoder poller.
// Used by bep_poll, bep_emit and button_and_encoder_poller_core; no dependencies.
package bep_pkg;

  localparam int NUM_BUTTONS_DEF  = 8;
  localparam int NUM_ENCODERS_DEF = 2;
  localparam int SPEED_MAX_DEF    = 1023;

  // Fixed field widths
  localparam int BUTTON_W  = 8;
  localparam int PHASE_W   = 2;
  localparam int STEP_W    = 9;
  localparam int SRC_W     = 3;
  localparam int TICK_W    = 16;
  localparam int HOLD_W    = 8;
  localparam int INCR_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Speed is divided by four to give the step magnitude
  localparam int SPEED_SHIFT = 2;
  localparam int STEP_MAG_MAX = 255;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_POLL_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENCODER_POLL_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_POLLS         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_INCREMENT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTONS_IN_USE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENCODERS_IN_USE    = 3'd5;

  // Register reset values
  localparam logic [TICK_W-1:0] KEY_POLL_LIMIT_RST     = 16'd100;
  localparam logic [TICK_W-1:0] ENCODER_POLL_LIMIT_RST = 16'd10;
  localparam logic [HOLD_W-1:0] HOLD_POLLS_RST         = 8'd50;
  localparam logic [INCR_W-1:0] SPEED_INCREMENT_RST    = 8'd5;

  typedef enum logic [1:0] {
    EV_KEY_DOWN  = 2'd0,
    EV_KEY_UP    = 2'd1,
    EV_ENC_MOVE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [TICK_W-1:0] key_poll_limit;
    logic [TICK_W-1:0] encoder_poll_limit;
    logic [HOLD_W-1:0] hold_polls;
    logic [INCR_W-1:0] speed_increment;
    logic [3:0]        buttons_in_use;
    logic [1:0]        encoders_in_use;
  } cfg_t;

endpackage

@@ rtl/core/button_and_encoder_poller_core.sv @@
// Top level of the button and rotary encoder poller.
// Depends on bep_pkg, bep_poll and bep_emit.
//
// Usage:
//   Each transaction on the item channel (item_valid / item_stall) is one
//   timer tick with sampled button and encoder pin levels. The block polls
//   the buttons and encoders when their tick counters pass their limits and
//   sends the resulting events on the event channel (event_valid /
//   event_stall), one per transaction, last_of_tick set on the final event
//   of a tick. A tick that causes no event produces no transaction.
//   Configuration registers are written over cfg_valid / cfg_ready with
//   cfg_index and cfg_data; cfg_ready is always high. Write only while idle.
// Flow:
//   The events of an accepted tick pass from the pending register to the
//   single result register, which sends one event a cycle while event_stall is
//   low; the next tick is accepted as the last event of a tick is sent, and
//   ticks without events are accepted every cycle.
// Reset (rst, synchronous) restores register defaults, clears all counters,
//   button and encoder state, sets speeds to one and drops pending events.
// While event_stall is high the current event holds and item_stall rises as
//   soon as events of the accepted tick are still waiting.
module button_and_encoder_poller_core #(
  parameter int NUM_BUTTONS  = bep_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_ENCODERS = bep_pkg::NUM_ENCODERS_DEF,
  parameter int SPEED_MAX    = bep_pkg::SPEED_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bep_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [bep_pkg::BUTTON_W-1:0]      button_levels,
  input  logic [bep_pkg::PHASE_W-1:0]       phase_a_levels,
  input  logic [bep_pkg::PHASE_W-1:0]       phase_b_levels,
  output logic                              event_valid,
  input  logic                              event_stall,
  output logic [1:0]                        event_kind,
  output logic [bep_pkg::SRC_W-1:0]         source_index,
  output logic signed [bep_pkg::STEP_W-1:0] step,
  output logic                              last_of_tick
);

  bep_pkg::cfg_t                  cfg;
  logic                           accept;
  logic [NUM_BUTTONS-1:0]         key_hit;
  logic [NUM_BUTTONS-1:0]         key_up;
  logic [NUM_ENCODERS-1:0]        enc_hit;
  logic [NUM_ENCODERS-1:0][bep_pkg::STEP_W-1:0] enc_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_poll_limit     <= bep_pkg::KEY_POLL_LIMIT_RST;
      cfg.encoder_poll_limit <= bep_pkg::ENCODER_POLL_LIMIT_RST;
      cfg.hold_polls         <= bep_pkg::HOLD_POLLS_RST;
      cfg.speed_increment    <= bep_pkg::SPEED_INCREMENT_RST;
      cfg.buttons_in_use     <= '0;
      cfg.encoders_in_use    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bep_pkg::REG_KEY_POLL_LIMIT:     cfg.key_poll_limit     <= cfg_data;
        bep_pkg::REG_ENCODER_POLL_LIMIT: cfg.encoder_poll_limit <= cfg_data;
        bep_pkg::REG_HOLD_POLLS:         cfg.hold_polls         <= cfg_data[7:0];
        bep_pkg::REG_SPEED_INCREMENT:    cfg.speed_increment    <= cfg_data[7:0];
        bep_pkg::REG_BUTTONS_IN_USE:     cfg.buttons_in_use     <= cfg_data[3:0];
        bep_pkg::REG_ENCODERS_IN_USE:    cfg.encoders_in_use    <= cfg_data[1:0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  bep_poll #(
    .NUM_BUTTONS  (NUM_BUTTONS),
    .NUM_ENCODERS (NUM_ENCODERS),
    .SPEED_MAX    (SPEED_MAX)
  ) u_poll (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .button_levels  (button_levels),
    .phase_a_levels (phase_a_levels),
    .phase_b_levels (phase_b_levels),
    .key_hit        (key_hit),
    .key_up         (key_up),
    .enc_hit        (enc_hit),
    .enc_step       (enc_step)
  );

  bep_emit #(
    .NUM_BUTTONS  (NUM_BUTTONS),
    .NUM_ENCODERS (NUM_ENCODERS)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .accept       (accept),
    .key_hit      (key_hit),
    .key_up       (key_up),
    .enc_hit      (enc_hit),
    .enc_step     (enc_step),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_kind   (event_kind),
    .source_index (source_index),
    .step         (step),
    .last_of_tick (last_of_tick)
  );

endmodule

@@ rtl/core/bep_poll.sv @@
// Poll counters, button and encoder state, and the event set of one tick.
// Depends on bep_pkg. Events are combinational from state and the tick's pins.
module bep_poll #(
  parameter int NUM_BUTTONS  = bep_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_ENCODERS = bep_pkg::NUM_ENCODERS_DEF,
  parameter int SPEED_MAX    = bep_pkg::SPEED_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bep_pkg::cfg_t                          cfg,
  input  logic                                   accept,
  input  logic [bep_pkg::BUTTON_W-1:0]           button_levels,
  input  logic [bep_pkg::PHASE_W-1:0]            phase_a_levels,
  input  logic [bep_pkg::PHASE_W-1:0]            phase_b_levels,
  output logic [NUM_BUTTONS-1:0]                 key_hit,
  output logic [NUM_BUTTONS-1:0]                 key_up,
  output logic [NUM_ENCODERS-1:0]                enc_hit,
  output logic [NUM_ENCODERS-1:0][bep_pkg::STEP_W-1:0] enc_step
);

  localparam int SW   = $clog2(SPEED_MAX + 1);
  localparam int SUMW = ((SW > bep_pkg::INCR_W) ? SW : bep_pkg::INCR_W) + 1;
  localparam int KLW  = (NUM_BUTTONS > bep_pkg::BUTTON_W) ? NUM_BUTTONS : bep_pkg::BUTTON_W;
  localparam int ELW  = (NUM_ENCODERS > bep_pkg::PHASE_W) ? NUM_ENCODERS : bep_pkg::PHASE_W;

  logic [bep_pkg::TICK_W-1:0] key_tick_count, key_tick_count_next;
  logic [bep_pkg::TICK_W-1:0] encoder_tick_count, encoder_tick_count_next;
  logic [NUM_BUTTONS-1:0]     button_down, button_down_next;
  logic [NUM_ENCODERS-1:0]    last_phase_a, last_phase_a_next;
  logic [NUM_ENCODERS-1:0]    last_phase_b, last_phase_b_next;
  logic [bep_pkg::HOLD_W-1:0] hold_count [NUM_ENCODERS];
  logic [bep_pkg::HOLD_W-1:0] hold_count_next [NUM_ENCODERS];
  logic [SW-1:0]              encoder_speed [NUM_ENCODERS];
  logic [SW-1:0]              encoder_speed_next [NUM_ENCODERS];

  logic [bep_pkg::TICK_W-1:0] key_inc, enc_inc;
  logic                       key_poll, enc_poll;
  logic [KLW-1:0]             key_lv;
  logic [ELW-1:0]             a_lv, b_lv;

  assign key_inc  = key_tick_count + 1'b1;
  assign enc_inc  = encoder_tick_count + 1'b1;
  assign key_poll = key_inc > cfg.key_poll_limit;
  assign enc_poll = enc_inc > cfg.encoder_poll_limit;
  // Pins beyond the input fields read low
  assign key_lv   = KLW'(button_levels);
  assign a_lv     = ELW'(phase_a_levels);
  assign b_lv     = ELW'(phase_b_levels);

  always_comb begin
    key_tick_count_next = key_poll ? '0 : key_inc;
    button_down_next    = button_down;
    key_hit             = '0;
    key_up              = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (key_poll && (i < 32'(cfg.buttons_in_use))) begin
        if (key_lv[i] != button_down[i]) begin
          key_hit[i]          = 1'b1;
          key_up[i]           = !key_lv[i];
          button_down_next[i] = key_lv[i];
        end
      end
    end
  end

  always_comb begin
    logic [SUMW-1:0]            mag;
    logic [SUMW-1:0]            sum;
    logic [bep_pkg::INCR_W-1:0] mag8;
    logic [SW-1:0]              speed_t;
    logic [bep_pkg::HOLD_W-1:0] hold_t;
    logic                       move;
    mag = '0;
    sum = '0;
    mag8 = '0;
    speed_t = '0;
    hold_t = '0;
    move = 1'b0;
    encoder_tick_count_next = enc_poll ? '0 : enc_inc;
    last_phase_a_next       = last_phase_a;
    last_phase_b_next       = last_phase_b;
    enc_hit                 = '0;
    enc_step                = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      hold_count_next[i]    = hold_count[i];
      encoder_speed_next[i] = encoder_speed[i];
      if (enc_poll && (i < 32'(cfg.encoders_in_use))) begin
        move = last_phase_a[i] && !a_lv[i] && !b_lv[i];
        // Magnitude is speed / 4, kept within 1 .. 255
        mag = SUMW'(encoder_speed[i] >> bep_pkg::SPEED_SHIFT);
        if (mag == '0) begin
          mag8 = 8'd1;
        end else if (mag > SUMW'(bep_pkg::STEP_MAG_MAX)) begin
          mag8 = 8'(bep_pkg::STEP_MAG_MAX);
        end else begin
          mag8 = mag[bep_pkg::INCR_W-1:0];
        end
        sum = SUMW'(encoder_speed[i]) + SUMW'(cfg.speed_increment);
        speed_t = encoder_speed[i];
        hold_t  = hold_count[i];
        if (move) begin
          enc_hit[i]  = 1'b1;
          enc_step[i] = last_phase_b[i] ? {1'b0, mag8} : 9'(-{1'b0, mag8});
          hold_t      = cfg.hold_polls;
          speed_t     = (sum > SUMW'(SPEED_MAX)) ? SW'(SPEED_MAX) : sum[SW-1:0];
        end
        last_phase_a_next[i] = a_lv[i];
        last_phase_b_next[i] = b_lv[i];
        if (hold_t != '0) begin
          hold_count_next[i]    = hold_t - 1'b1;
          encoder_speed_next[i] = speed_t;
        end else begin
          hold_count_next[i]    = '0;
          encoder_speed_next[i] = SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_tick_count     <= '0;
      encoder_tick_count <= '0;
      button_down        <= '0;
      last_phase_a       <= '0;
      last_phase_b       <= '0;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        hold_count[i]    <= '0;
        encoder_speed[i] <= SW'(1);
      end
    end else if (accept) begin
      key_tick_count     <= key_tick_count_next;
      encoder_tick_count <= encoder_tick_count_next;
      button_down        <= button_down_next;
      last_phase_a       <= last_phase_a_next;
      last_phase_b       <= last_phase_b_next;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        hold_count[i]    <= hold_count_next[i];
        encoder_speed[i] <= encoder_speed_next[i];
      end
    end
  end

endmodule

@@ rtl/core/bep_emit.sv @@
// Pending event register of one tick and the result register that sends them out.
// Depends on bep_pkg. Events leave lowest index first, keys before encoders.
module bep_emit #(
  parameter int NUM_BUTTONS  = bep_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_ENCODERS = bep_pkg::NUM_ENCODERS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  output logic                                   accept,
  input  logic [NUM_BUTTONS-1:0]                 key_hit,
  input  logic [NUM_BUTTONS-1:0]                 key_up,
  input  logic [NUM_ENCODERS-1:0]                enc_hit,
  input  logic [NUM_ENCODERS-1:0][bep_pkg::STEP_W-1:0] enc_step,
  output logic                                   event_valid,
  input  logic                                   event_stall,
  output logic [1:0]                             event_kind,
  output logic [bep_pkg::SRC_W-1:0]              source_index,
  output logic signed [bep_pkg::STEP_W-1:0]      step,
  output logic                                   last_of_tick
);

  localparam int PW = NUM_BUTTONS + NUM_ENCODERS;

  logic [PW-1:0]                  pend;
  logic [NUM_BUTTONS-1:0]         pend_up;
  logic [NUM_ENCODERS-1:0][bep_pkg::STEP_W-1:0] pend_step;

  logic [PW-1:0]                  sel_oh;
  logic [PW-1:0]                  rest;
  logic                           out_free;
  logic                           pop;
  bep_pkg::kind_t                 sel_kind;
  logic [bep_pkg::SRC_W-1:0]      sel_idx;
  logic [bep_pkg::STEP_W-1:0]     sel_step;

  // Lowest set bit of the pending mask
  assign sel_oh     = pend & (~pend + PW'(1));
  assign rest       = pend & ~sel_oh;
  assign out_free   = !event_valid || !event_stall;
  assign pop        = (pend != '0) && out_free;
  assign item_stall = pop ? (rest != '0) : (pend != '0);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    sel_idx  = '0;
    sel_step = '0;
    sel_kind = ((pend_up & sel_oh[NUM_BUTTONS-1:0]) != '0) ? bep_pkg::EV_KEY_UP
                                                           : bep_pkg::EV_KEY_DOWN;
    for (int j = 0; j < NUM_BUTTONS; j++) begin
      if (sel_oh[j]) begin
        sel_idx = sel_idx | bep_pkg::SRC_W'(j);
      end
    end
    for (int j = 0; j < NUM_ENCODERS; j++) begin
      if (sel_oh[NUM_BUTTONS + j]) begin
        sel_kind = bep_pkg::EV_ENC_MOVE;
        sel_idx  = sel_idx | bep_pkg::SRC_W'(j);
        sel_step = sel_step | pend_step[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (accept) begin
      pend <= {enc_hit, key_hit};
    end else if (pop) begin
      pend <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_up   <= key_up;
      pend_step <= enc_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (out_free) begin
      event_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      event_kind   <= sel_kind;
      source_index <= sel_idx;
      step         <= sel_step;
      last_of_tick <= (rest == '0);
    end
  end

  a_sel_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(sel_oh))
    else $error("pending event select is not one-hot");

  a_pend_moves: assert property (@(posedge clk) disable iff (rst)
    (pend != '0) && !event_stall |=> event_valid)
    else $error("pending event did not reach the result register");

  a_load_kept: assert property (@(posedge clk) disable iff (rst)
    accept && ({enc_hit, key_hit} != '0) |=> (pend != '0) || event_valid)
    else $error("events of an accepted tick were lost");

  a_key_step: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind != bep_pkg::EV_ENC_MOVE) |-> (step == '0))
    else $error("key event carries a nonzero step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !pop || (rest == '0))
    else $error("tick accepted while events of the previous tick remain");

endmodule
